// ===== design/dhcpc_pkg.sv =====
`default_nettype none

package dhcpc_pkg;

    localparam int unsigned ADDR_W     = 32;
    localparam int unsigned ACT_W      = 3;
    localparam int unsigned STATE_W    = 2;
    localparam int unsigned RETRY_W    = 3;
    localparam int unsigned BASE_W     = 4;
    localparam int unsigned HDR_W      = 24;
    localparam int unsigned MTYPE_W    = 8;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 4;

    localparam logic [STATE_W-1:0] ST_INIT       = 2'd0;
    localparam logic [STATE_W-1:0] ST_SELECTING  = 2'd1;
    localparam logic [STATE_W-1:0] ST_REQUESTING = 2'd2;
    localparam logic [STATE_W-1:0] ST_BOUND      = 2'd3;

    localparam logic [ACT_W-1:0] ACT_NONE     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_DISCOVER = 3'd1;
    localparam logic [ACT_W-1:0] ACT_REQUEST  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_GW_ARP   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_ANNOUNCE = 3'd4;

    localparam logic [MTYPE_W-1:0] MSG_OFFER = 8'd2;
    localparam logic [MTYPE_W-1:0] MSG_ACK   = 8'd5;
    localparam logic [MTYPE_W-1:0] MSG_NAK   = 8'd6;

    localparam logic [HDR_W-1:0]  HDR_EXPECTED    = 24'h020106;
    localparam logic [ADDR_W-1:0] COOKIE_EXPECTED = 32'h63825363;

    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF     = 1'd1;

    localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = 3'd4;
    localparam logic [BASE_W-1:0]  BACKOFF_RST     = 4'd4;

    typedef struct packed {
        logic                opcode;
        logic [ADDR_W-1:0]   now_secs;
        logic [ADDR_W-1:0]   tick_count;
        logic                gateway_resolved;
        logic [HDR_W-1:0]    rx_fixed_header;
        logic [ADDR_W-1:0]   rx_cookie;
        logic [ADDR_W-1:0]   rx_xid;
        logic [MTYPE_W-1:0]  rx_msg_type;
        logic [ADDR_W-1:0]   rx_your_ip;
        logic [ADDR_W-1:0]   rx_server_id;
        logic [ADDR_W-1:0]   rx_gateway;
        logic [ADDR_W-1:0]   rx_mask;
    } t_item;

    typedef struct packed {
        logic [ACT_W-1:0]    send_action;
        logic [ADDR_W-1:0]   xid_out;
        logic [ADDR_W-1:0]   requested_ip;
        logic [ADDR_W-1:0]   server_id_out;
        logic [ADDR_W-1:0]   local_ip;
        logic [ADDR_W-1:0]   gateway_ip;
        logic [ADDR_W-1:0]   subnet_mask;
        logic                bound;
        logic                clear_gateway_known;
    } t_result;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

endpackage

`default_nettype wire

// ===== design/dhcp_client_state_machine.sv =====
// channel   direction  handshake                      payload
// input     in         i_valid / o_stall              i_opcode .. i_rx_mask
// result    out        o_valid / i_stall              o_send_action .. o_clear_gateway_known
// config    in         i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// one transaction per cycle while i_stall does not hold the result; the path runs
// through an input register, then the state update and the result register
// reset (synchronous, active low) puts the client in init with lease fields cleared
// o_stall rises only when both registers hold data and i_stall is high
// config writes are always ready
`default_nettype none

module dhcp_client_state_machine (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,

    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic                            i_opcode,
    input  wire logic [dhcpc_pkg::ADDR_W-1:0]    i_now_secs,
    input  wire logic [dhcpc_pkg::ADDR_W-1:0]    i_tick_count,
    input  wire logic                            i_gateway_resolved,
    input  wire logic [dhcpc_pkg::HDR_W-1:0]     i_rx_fixed_header,
    input  wire logic [dhcpc_pkg::ADDR_W-1:0]    i_rx_cookie,
    input  wire logic [dhcpc_pkg::ADDR_W-1:0]    i_rx_xid,
    input  wire logic [dhcpc_pkg::MTYPE_W-1:0]   i_rx_msg_type,
    input  wire logic [dhcpc_pkg::ADDR_W-1:0]    i_rx_your_ip,
    input  wire logic [dhcpc_pkg::ADDR_W-1:0]    i_rx_server_id,
    input  wire logic [dhcpc_pkg::ADDR_W-1:0]    i_rx_gateway,
    input  wire logic [dhcpc_pkg::ADDR_W-1:0]    i_rx_mask,

    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [dhcpc_pkg::ACT_W-1:0]          o_send_action,
    output logic [dhcpc_pkg::ADDR_W-1:0]         o_xid_out,
    output logic [dhcpc_pkg::ADDR_W-1:0]         o_requested_ip,
    output logic [dhcpc_pkg::ADDR_W-1:0]         o_server_id_out,
    output logic [dhcpc_pkg::ADDR_W-1:0]         o_local_ip,
    output logic [dhcpc_pkg::ADDR_W-1:0]         o_gateway_ip,
    output logic [dhcpc_pkg::ADDR_W-1:0]         o_subnet_mask,
    output logic                                 o_bound,
    output logic                                 o_clear_gateway_known,

    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [dhcpc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [dhcpc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    dhcpc_pkg::t_item   in_item;
    dhcpc_pkg::t_item   stage_item;
    dhcpc_pkg::t_result core_result;
    dhcpc_pkg::t_result r_result;
    dhcpc_pkg::t_cfg_wr cfg_wr;
    logic               stage_valid;
    logic               advance;
    logic               load;
    logic               r_out_valid;
    logic               n_out_valid;

    always_comb begin
        in_item.opcode           = i_opcode;
        in_item.now_secs         = i_now_secs;
        in_item.tick_count       = i_tick_count;
        in_item.gateway_resolved = i_gateway_resolved;
        in_item.rx_fixed_header  = i_rx_fixed_header;
        in_item.rx_cookie        = i_rx_cookie;
        in_item.rx_xid           = i_rx_xid;
        in_item.rx_msg_type      = i_rx_msg_type;
        in_item.rx_your_ip       = i_rx_your_ip;
        in_item.rx_server_id     = i_rx_server_id;
        in_item.rx_gateway       = i_rx_gateway;
        in_item.rx_mask          = i_rx_mask;
    end

    assign o_cfg_ready  = 1'b1;
    assign cfg_wr.we    = i_cfg_valid;
    assign cfg_wr.index = i_cfg_index;
    assign cfg_wr.data  = i_cfg_data;

    assign advance = stage_valid && (!r_out_valid || !i_stall);
    assign o_stall = stage_valid && !advance;
    assign load    = i_valid && !o_stall;

    dhcpc_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (load),
        .i_consume (advance),
        .i_item    (in_item),
        .o_valid   (stage_valid),
        .o_item    (stage_item)
    );

    dhcpc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_wr),
        .i_step   (advance),
        .i_item   (stage_item),
        .o_result (core_result)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= core_result;
        end
    end

    assign o_valid               = r_out_valid;
    assign o_send_action         = r_result.send_action;
    assign o_xid_out             = r_result.xid_out;
    assign o_requested_ip        = r_result.requested_ip;
    assign o_server_id_out       = r_result.server_id_out;
    assign o_local_ip            = r_result.local_ip;
    assign o_gateway_ip          = r_result.gateway_ip;
    assign o_subnet_mask         = r_result.subnet_mask;
    assign o_bound               = r_result.bound;
    assign o_clear_gateway_known = r_result.clear_gateway_known;

endmodule

`default_nettype wire

// ===== design/dhcpc_in_stage.sv =====
`default_nettype none

module dhcpc_in_stage (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  wire logic            i_consume,
    input  wire dhcpc_pkg::t_item i_item,
    output logic                 o_valid,
    output dhcpc_pkg::t_item     o_item
);

    logic             r_valid;
    logic             n_valid;
    dhcpc_pkg::t_item r_item;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_consume) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ===== design/dhcpc_core.sv =====
`default_nettype none

module dhcpc_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire dhcpc_pkg::t_cfg_wr i_cfg,
    input  wire logic              i_step,
    input  wire dhcpc_pkg::t_item  i_item,
    output dhcpc_pkg::t_result     o_result
);

    logic [dhcpc_pkg::RETRY_W-1:0] r_retry_limit;
    logic [dhcpc_pkg::BASE_W-1:0]  r_base;

    logic [dhcpc_pkg::STATE_W-1:0] r_state, n_state;
    logic [dhcpc_pkg::ADDR_W-1:0]  r_xid, n_xid;
    logic [dhcpc_pkg::ADDR_W-1:0]  r_offered, n_offered;
    logic [dhcpc_pkg::ADDR_W-1:0]  r_server, n_server;
    logic [dhcpc_pkg::RETRY_W-1:0] r_retry, n_retry;
    logic [dhcpc_pkg::ADDR_W-1:0]  r_deadline, n_deadline;
    logic [dhcpc_pkg::ADDR_W-1:0]  r_lease_ip, n_lease_ip;
    logic [dhcpc_pkg::ADDR_W-1:0]  r_lease_gw, n_lease_gw;
    logic [dhcpc_pkg::ADDR_W-1:0]  r_lease_mask, n_lease_mask;

    logic [dhcpc_pkg::ACT_W-1:0]   action;
    logic                          clear_gw;

    // resend path shared by init, selecting and requesting
    logic [dhcpc_pkg::STATE_W-1:0] rs_state;
    logic [dhcpc_pkg::RETRY_W-1:0] rs_retry;
    logic [dhcpc_pkg::ADDR_W-1:0]  rs_deadline;
    logic [dhcpc_pkg::ACT_W-1:0]   rs_act;
    logic                          timed_out;
    logic                          reply_ok;
    logic                          same_server;

    always_comb begin
        n_state      = r_state;
        n_xid        = r_xid;
        n_offered    = r_offered;
        n_server     = r_server;
        n_retry      = r_retry;
        n_deadline   = r_deadline;
        n_lease_ip   = r_lease_ip;
        n_lease_gw   = r_lease_gw;
        n_lease_mask = r_lease_mask;
        action       = dhcpc_pkg::ACT_NONE;
        clear_gw     = 1'b0;

        // init restarts with deadline and retry count at zero
        rs_state    = (r_state == dhcpc_pkg::ST_INIT) ? dhcpc_pkg::ST_SELECTING : r_state;
        rs_retry    = (r_state == dhcpc_pkg::ST_INIT) ? '0 : r_retry;
        rs_deadline = (r_state == dhcpc_pkg::ST_INIT) ? '0 : r_deadline;
        rs_act      = (r_state == dhcpc_pkg::ST_REQUESTING) ? dhcpc_pkg::ACT_REQUEST
                                                           : dhcpc_pkg::ACT_DISCOVER;
        timed_out   = (i_item.now_secs >= rs_deadline);

        reply_ok    = (i_item.rx_fixed_header == dhcpc_pkg::HDR_EXPECTED) &&
                      (i_item.rx_cookie == dhcpc_pkg::COOKIE_EXPECTED) &&
                      (i_item.rx_xid == r_xid);
        same_server = (i_item.rx_server_id == r_server);

        if (!i_item.opcode) begin
            case (r_state)
                dhcpc_pkg::ST_INIT, dhcpc_pkg::ST_SELECTING,
                dhcpc_pkg::ST_REQUESTING: begin
                    if (r_state == dhcpc_pkg::ST_INIT) begin
                        n_lease_ip   = '0;
                        n_lease_gw   = '0;
                        n_lease_mask = '0;
                        n_xid        = ~i_item.tick_count;
                    end
                    n_state    = rs_state;
                    n_retry    = rs_retry;
                    n_deadline = rs_deadline;
                    if (timed_out) begin
                        if (rs_retry < r_retry_limit) begin
                            n_deadline = i_item.now_secs +
                                (dhcpc_pkg::ADDR_W'(r_base) << rs_retry);
                            n_retry    = rs_retry + 1'b1;
                            action     = rs_act;
                        end else begin
                            n_state = dhcpc_pkg::ST_INIT;
                        end
                    end
                end
                default: begin
                    if (!i_item.gateway_resolved && (i_item.now_secs >= r_deadline)) begin
                        n_deadline = i_item.now_secs + dhcpc_pkg::ADDR_W'(r_base);
                        action     = dhcpc_pkg::ACT_GW_ARP;
                    end
                end
            endcase
        end else if (reply_ok) begin
            case (i_item.rx_msg_type)
                dhcpc_pkg::MSG_OFFER: begin
                    if (r_state == dhcpc_pkg::ST_SELECTING) begin
                        n_state    = dhcpc_pkg::ST_REQUESTING;
                        n_deadline = '0;
                        n_retry    = '0;
                        n_offered  = i_item.rx_your_ip;
                        n_server   = i_item.rx_server_id;
                    end
                end
                dhcpc_pkg::MSG_ACK: begin
                    if (r_state == dhcpc_pkg::ST_REQUESTING && same_server) begin
                        n_state      = dhcpc_pkg::ST_BOUND;
                        n_lease_ip   = i_item.rx_your_ip;
                        n_lease_gw   = i_item.rx_gateway;
                        n_lease_mask = i_item.rx_mask;
                        n_deadline   = '0;
                        clear_gw     = 1'b1;
                        action       = dhcpc_pkg::ACT_ANNOUNCE;
                    end
                end
                dhcpc_pkg::MSG_NAK: begin
                    if ((r_state inside {dhcpc_pkg::ST_REQUESTING, dhcpc_pkg::ST_BOUND})
                        && same_server) begin
                        n_state = dhcpc_pkg::ST_INIT;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_limit <= dhcpc_pkg::RETRY_LIMIT_RST;
            r_base        <= dhcpc_pkg::BACKOFF_RST;
        end else if (i_cfg.we) begin
            case (i_cfg.index)
                dhcpc_pkg::CFG_RETRY_LIMIT: r_retry_limit <= i_cfg.data[dhcpc_pkg::RETRY_W-1:0];
                dhcpc_pkg::CFG_BACKOFF:     r_base        <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= dhcpc_pkg::ST_INIT;
            r_xid        <= '0;
            r_offered    <= '0;
            r_server     <= '0;
            r_retry      <= '0;
            r_deadline   <= '0;
            r_lease_ip   <= '0;
            r_lease_gw   <= '0;
            r_lease_mask <= '0;
        end else if (i_step) begin
            r_state      <= n_state;
            r_xid        <= n_xid;
            r_offered    <= n_offered;
            r_server     <= n_server;
            r_retry      <= n_retry;
            r_deadline   <= n_deadline;
            r_lease_ip   <= n_lease_ip;
            r_lease_gw   <= n_lease_gw;
            r_lease_mask <= n_lease_mask;
        end
    end

    always_comb begin
        o_result.send_action         = action;
        o_result.xid_out             = n_xid;
        o_result.requested_ip        = n_offered;
        o_result.server_id_out       = n_server;
        o_result.local_ip            = n_lease_ip;
        o_result.gateway_ip          = n_lease_gw;
        o_result.subnet_mask         = n_lease_mask;
        o_result.bound               = (n_state == dhcpc_pkg::ST_BOUND);
        o_result.clear_gateway_known = clear_gw;
    end

endmodule

`default_nettype wire

// ===== bench/tb_dhcp_client_state_machine.sv =====
`timescale 1ns / 100ps

module tb_dhcp_client_state_machine;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_valid = 1'b0;
    logic                             o_stall;
    logic                             i_opcode = 1'b0;
    logic [dhcpc_pkg::ADDR_W-1:0]     i_now_secs = '0;
    logic [dhcpc_pkg::ADDR_W-1:0]     i_tick_count = '0;
    logic                             i_gateway_resolved = 1'b0;
    logic [dhcpc_pkg::HDR_W-1:0]      i_rx_fixed_header = '0;
    logic [dhcpc_pkg::ADDR_W-1:0]     i_rx_cookie = '0;
    logic [dhcpc_pkg::ADDR_W-1:0]     i_rx_xid = '0;
    logic [dhcpc_pkg::MTYPE_W-1:0]    i_rx_msg_type = '0;
    logic [dhcpc_pkg::ADDR_W-1:0]     i_rx_your_ip = '0;
    logic [dhcpc_pkg::ADDR_W-1:0]     i_rx_server_id = '0;
    logic [dhcpc_pkg::ADDR_W-1:0]     i_rx_gateway = '0;
    logic [dhcpc_pkg::ADDR_W-1:0]     i_rx_mask = '0;
    logic                             o_valid;
    logic                             i_stall = 1'b0;
    logic [dhcpc_pkg::ACT_W-1:0]      o_send_action;
    logic [dhcpc_pkg::ADDR_W-1:0]     o_xid_out;
    logic [dhcpc_pkg::ADDR_W-1:0]     o_requested_ip;
    logic [dhcpc_pkg::ADDR_W-1:0]     o_server_id_out;
    logic [dhcpc_pkg::ADDR_W-1:0]     o_local_ip;
    logic [dhcpc_pkg::ADDR_W-1:0]     o_gateway_ip;
    logic [dhcpc_pkg::ADDR_W-1:0]     o_subnet_mask;
    logic                             o_bound;
    logic                             o_clear_gateway_known;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic [dhcpc_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [dhcpc_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    dhcp_client_state_machine DUT (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_valid),
        .o_stall               (o_stall),
        .i_opcode              (i_opcode),
        .i_now_secs            (i_now_secs),
        .i_tick_count          (i_tick_count),
        .i_gateway_resolved    (i_gateway_resolved),
        .i_rx_fixed_header     (i_rx_fixed_header),
        .i_rx_cookie           (i_rx_cookie),
        .i_rx_xid              (i_rx_xid),
        .i_rx_msg_type         (i_rx_msg_type),
        .i_rx_your_ip          (i_rx_your_ip),
        .i_rx_server_id        (i_rx_server_id),
        .i_rx_gateway          (i_rx_gateway),
        .i_rx_mask             (i_rx_mask),
        .o_valid               (o_valid),
        .i_stall               (i_stall),
        .o_send_action         (o_send_action),
        .o_xid_out             (o_xid_out),
        .o_requested_ip        (o_requested_ip),
        .o_server_id_out       (o_server_id_out),
        .o_local_ip            (o_local_ip),
        .o_gateway_ip          (o_gateway_ip),
        .o_subnet_mask         (o_subnet_mask),
        .o_bound               (o_bound),
        .o_clear_gateway_known (o_clear_gateway_known),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // client model state
    logic [dhcpc_pkg::STATE_W-1:0] m_state = dhcpc_pkg::ST_INIT;
    logic [dhcpc_pkg::ADDR_W-1:0]  m_xid = '0;
    logic [dhcpc_pkg::ADDR_W-1:0]  m_offer_ip = '0;
    logic [dhcpc_pkg::ADDR_W-1:0]  m_server = '0;
    logic [dhcpc_pkg::RETRY_W-1:0] m_retries = '0;
    logic [dhcpc_pkg::ADDR_W-1:0]  m_deadline = '0;
    logic [dhcpc_pkg::ADDR_W-1:0]  m_lease_ip = '0;
    logic [dhcpc_pkg::ADDR_W-1:0]  m_lease_gw = '0;
    logic [dhcpc_pkg::ADDR_W-1:0]  m_lease_mask = '0;
    logic [dhcpc_pkg::RETRY_W-1:0] m_retry_limit = dhcpc_pkg::RETRY_LIMIT_RST;
    logic [dhcpc_pkg::BASE_W-1:0]  m_backoff = dhcpc_pkg::BACKOFF_RST;

    dhcpc_pkg::t_result           pending_results[$];
    int unsigned                  mismatch_count = 0;
    bit                           feed_gaps = 1'b1;
    bit                           drain_stalls = 1'b1;
    logic [dhcpc_pkg::ADDR_W-1:0] sim_secs = '0;

    function automatic logic [dhcpc_pkg::ACT_W-1:0] resend_on_timeout(
        logic [dhcpc_pkg::ADDR_W-1:0] now, logic [dhcpc_pkg::ACT_W-1:0] act);
        if (now < m_deadline)
            return dhcpc_pkg::ACT_NONE;
        if (m_retries < m_retry_limit) begin
            m_deadline = now + (32'(m_backoff) << m_retries);
            m_retries = m_retries + 3'd1;
            return act;
        end
        m_state = dhcpc_pkg::ST_INIT;
        return dhcpc_pkg::ACT_NONE;
    endfunction

    function automatic dhcpc_pkg::t_result predict_client(dhcpc_pkg::t_item it);
        dhcpc_pkg::t_result          r;
        logic [dhcpc_pkg::ACT_W-1:0] act;
        logic                        clr;
        act = dhcpc_pkg::ACT_NONE;
        clr = 1'b0;
        if (it.opcode == 1'b0) begin
            case (m_state)
                dhcpc_pkg::ST_INIT: begin
                    m_lease_ip = '0;
                    m_lease_gw = '0;
                    m_lease_mask = '0;
                    m_state = dhcpc_pkg::ST_SELECTING;
                    m_xid = ~it.tick_count;
                    m_deadline = '0;
                    m_retries = '0;
                    act = resend_on_timeout(it.now_secs, dhcpc_pkg::ACT_DISCOVER);
                end
                dhcpc_pkg::ST_SELECTING:
                    act = resend_on_timeout(it.now_secs, dhcpc_pkg::ACT_DISCOVER);
                dhcpc_pkg::ST_REQUESTING:
                    act = resend_on_timeout(it.now_secs, dhcpc_pkg::ACT_REQUEST);
                default: begin
                    if (!it.gateway_resolved && it.now_secs >= m_deadline) begin
                        m_deadline = it.now_secs + 32'(m_backoff);
                        act = dhcpc_pkg::ACT_GW_ARP;
                    end
                end
            endcase
        end else if (it.rx_fixed_header == dhcpc_pkg::HDR_EXPECTED
                     && it.rx_cookie == dhcpc_pkg::COOKIE_EXPECTED
                     && it.rx_xid == m_xid) begin
            if (it.rx_msg_type == dhcpc_pkg::MSG_OFFER) begin
                if (m_state == dhcpc_pkg::ST_SELECTING) begin
                    m_state = dhcpc_pkg::ST_REQUESTING;
                    m_deadline = '0;
                    m_retries = '0;
                    m_offer_ip = it.rx_your_ip;
                    m_server = it.rx_server_id;
                end
            end else if (it.rx_msg_type == dhcpc_pkg::MSG_ACK) begin
                if (m_state == dhcpc_pkg::ST_REQUESTING && m_server == it.rx_server_id) begin
                    m_state = dhcpc_pkg::ST_BOUND;
                    m_lease_ip = it.rx_your_ip;
                    m_lease_gw = it.rx_gateway;
                    m_lease_mask = it.rx_mask;
                    m_deadline = '0;
                    clr = 1'b1;
                    act = dhcpc_pkg::ACT_ANNOUNCE;
                end
            end else if (it.rx_msg_type == dhcpc_pkg::MSG_NAK) begin
                if ((m_state == dhcpc_pkg::ST_REQUESTING || m_state == dhcpc_pkg::ST_BOUND)
                    && m_server == it.rx_server_id)
                    m_state = dhcpc_pkg::ST_INIT;
            end
        end
        r.send_action = act;
        r.xid_out = m_xid;
        r.requested_ip = m_offer_ip;
        r.server_id_out = m_server;
        r.local_ip = m_lease_ip;
        r.gateway_ip = m_lease_gw;
        r.subnet_mask = m_lease_mask;
        r.bound = (m_state == dhcpc_pkg::ST_BOUND);
        r.clear_gateway_known = clr;
        return r;
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t %s expected %h actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        dhcpc_pkg::t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t result expected none actual action %h xid %h", $time,
                         o_send_action, o_xid_out);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                compare_field("send_action", 32'(want.send_action), 32'(o_send_action));
                compare_field("xid_out", want.xid_out, o_xid_out);
                compare_field("requested_ip", want.requested_ip, o_requested_ip);
                compare_field("server_id_out", want.server_id_out, o_server_id_out);
                compare_field("local_ip", want.local_ip, o_local_ip);
                compare_field("gateway_ip", want.gateway_ip, o_gateway_ip);
                compare_field("subnet_mask", want.subnet_mask, o_subnet_mask);
                compare_field("bound", 32'(want.bound), 32'(o_bound));
                compare_field("clear_gateway_known", 32'(want.clear_gateway_known),
                              32'(o_clear_gateway_known));
            end
        end
    end

    always @(negedge i_clk) begin
        i_stall <= drain_stalls && ($urandom_range(0, 99) < 38);
    end

    task automatic send_event(dhcpc_pkg::t_item it);
        @(negedge i_clk);
        while (feed_gaps && $urandom_range(0, 99) < 38) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_opcode <= it.opcode;
        i_now_secs <= it.now_secs;
        i_tick_count <= it.tick_count;
        i_gateway_resolved <= it.gateway_resolved;
        i_rx_fixed_header <= it.rx_fixed_header;
        i_rx_cookie <= it.rx_cookie;
        i_rx_xid <= it.rx_xid;
        i_rx_msg_type <= it.rx_msg_type;
        i_rx_your_ip <= it.rx_your_ip;
        i_rx_server_id <= it.rx_server_id;
        i_rx_gateway <= it.rx_gateway;
        i_rx_mask <= it.rx_mask;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        pending_results.push_back(predict_client(it));
    endtask

    task automatic wait_for_drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(logic [dhcpc_pkg::CFG_IDX_W-1:0] idx,
                                  logic [dhcpc_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == dhcpc_pkg::CFG_RETRY_LIMIT)
            m_retry_limit = val[dhcpc_pkg::RETRY_W-1:0];
        else
            m_backoff = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(logic [dhcpc_pkg::RETRY_W-1:0] limit,
                              logic [dhcpc_pkg::BASE_W-1:0] base);
        wait_for_drain();
        write_register(dhcpc_pkg::CFG_RETRY_LIMIT, dhcpc_pkg::CFG_DATA_W'(limit));
        write_register(dhcpc_pkg::CFG_BACKOFF, base);
    endtask

    function automatic dhcpc_pkg::t_item random_item();
        dhcpc_pkg::t_item it;
        it.opcode = 1'($urandom_range(0, 1));
        it.now_secs = $urandom;
        it.tick_count = $urandom;
        it.gateway_resolved = 1'($urandom_range(0, 1));
        it.rx_fixed_header = 24'($urandom);
        it.rx_cookie = $urandom;
        it.rx_xid = $urandom;
        it.rx_msg_type = 8'($urandom);
        it.rx_your_ip = $urandom;
        it.rx_server_id = $urandom;
        it.rx_gateway = $urandom;
        it.rx_mask = $urandom;
        return it;
    endfunction

    function automatic dhcpc_pkg::t_item tick_event(logic [dhcpc_pkg::ADDR_W-1:0] now,
                                                    logic [dhcpc_pkg::ADDR_W-1:0] ticks,
                                                    logic gw_known);
        dhcpc_pkg::t_item it;
        it = random_item();
        it.opcode = 1'b0;
        it.now_secs = now;
        it.tick_count = ticks;
        it.gateway_resolved = gw_known;
        return it;
    endfunction

    // well-formed reply carrying the current transaction id
    function automatic dhcpc_pkg::t_item reply_event(logic [dhcpc_pkg::MTYPE_W-1:0] mtype,
                                                     logic [dhcpc_pkg::ADDR_W-1:0] sid);
        dhcpc_pkg::t_item it;
        it = random_item();
        it.opcode = 1'b1;
        it.rx_fixed_header = dhcpc_pkg::HDR_EXPECTED;
        it.rx_cookie = dhcpc_pkg::COOKIE_EXPECTED;
        it.rx_xid = m_xid;
        it.rx_msg_type = mtype;
        it.rx_server_id = sid;
        return it;
    endfunction

    function automatic logic [dhcpc_pkg::ADDR_W-1:0] next_now();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            sim_secs = sim_secs + $urandom_range(0, 3);
        else if (pick < 60)
            sim_secs = m_deadline;
        else if (pick < 70)
            sim_secs = m_deadline - 32'd1;
        else if (pick < 85)
            sim_secs = m_deadline + $urandom_range(1, 20);
        else if (pick < 93)
            sim_secs = $urandom;
        else
            sim_secs = 32'hFFFF_FFFF - $urandom_range(0, 20);
        return sim_secs;
    endfunction

    function automatic dhcpc_pkg::t_item gen_event();
        dhcpc_pkg::t_item              it;
        int unsigned                   pick;
        logic [dhcpc_pkg::MTYPE_W-1:0] mtype;
        logic [dhcpc_pkg::ADDR_W-1:0]  sid;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return random_item();
        if (pick < 55)
            return tick_event(next_now(), $urandom, $urandom_range(0, 99) < 25);
        pick = $urandom_range(0, 99);
        case (m_state)
            dhcpc_pkg::ST_SELECTING:
                mtype = (pick < 80) ? dhcpc_pkg::MSG_OFFER : 8'($urandom);
            dhcpc_pkg::ST_REQUESTING:
                mtype = (pick < 60) ? dhcpc_pkg::MSG_ACK :
                        (pick < 80) ? dhcpc_pkg::MSG_NAK :
                        (pick < 90) ? dhcpc_pkg::MSG_OFFER : 8'($urandom);
            dhcpc_pkg::ST_BOUND:
                mtype = (pick < 35) ? dhcpc_pkg::MSG_NAK :
                        (pick < 55) ? dhcpc_pkg::MSG_ACK : 8'($urandom);
            default:
                mtype = (pick < 50) ? dhcpc_pkg::MSG_OFFER : 8'($urandom);
        endcase
        sid = ($urandom_range(0, 99) < 85 && m_state != dhcpc_pkg::ST_SELECTING)
              ? m_server : $urandom;
        it = reply_event(mtype, sid);
        pick = $urandom_range(0, 99);
        if (pick < 4)
            it.rx_fixed_header = it.rx_fixed_header
                                 ^ (24'd1 << $urandom_range(0, dhcpc_pkg::HDR_W - 1));
        else if (pick < 8)
            it.rx_cookie = it.rx_cookie ^ (32'd1 << $urandom_range(0, 31));
        else if (pick < 12)
            it.rx_xid = it.rx_xid ^ (32'd1 << $urandom_range(0, 31));
        return it;
    endfunction

    task automatic run_random_traffic(int unsigned count);
        repeat (count) send_event(gen_event());
    endtask

    task automatic test_lease_sequence();
        dhcpc_pkg::t_item it;
        send_event(tick_event(32'd0, 32'd0, 1'b0));
        send_event(tick_event(32'd0, 32'hFFFF_FFFF, 1'b0));
        // hardware length other than 6
        it = reply_event(dhcpc_pkg::MSG_OFFER, 32'h0A00_0001);
        it.rx_fixed_header = 24'h020105;
        send_event(it);
        it = reply_event(dhcpc_pkg::MSG_OFFER, 32'h0A00_0001);
        it.rx_cookie = ~dhcpc_pkg::COOKIE_EXPECTED;
        send_event(it);
        it = reply_event(dhcpc_pkg::MSG_OFFER, 32'h0A00_0001);
        it.rx_xid = ~m_xid;
        send_event(it);
        send_event(reply_event(dhcpc_pkg::MSG_ACK, 32'h0A00_0001));
        send_event(reply_event(8'h00, 32'h0A00_0001));
        send_event(reply_event(8'hFF, 32'h0A00_0001));
        it = reply_event(dhcpc_pkg::MSG_OFFER, 32'hFFFF_FFFF);
        it.rx_your_ip = 32'hFFFF_FFFF;
        send_event(it);
        send_event(reply_event(dhcpc_pkg::MSG_OFFER, 32'h0000_0000));
        send_event(tick_event(32'd4, $urandom, 1'b0));
        send_event(reply_event(dhcpc_pkg::MSG_ACK, 32'h0000_0000));
        send_event(reply_event(dhcpc_pkg::MSG_NAK, 32'h0000_1234));
        it = reply_event(dhcpc_pkg::MSG_ACK, 32'hFFFF_FFFF);
        it.rx_gateway = 32'hFFFF_FFFF;
        it.rx_mask = 32'hFFFF_FFFF;
        send_event(it);
        send_event(tick_event(32'd100, $urandom, 1'b0));
        send_event(tick_event(32'd101, $urandom, 1'b0));
        send_event(tick_event(32'd200, $urandom, 1'b1));
        // nak while bound keeps the lease until the next init
        send_event(reply_event(dhcpc_pkg::MSG_NAK, 32'hFFFF_FFFF));
        send_event(tick_event(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
        send_event(tick_event(32'd3, $urandom, 1'b0));
        send_event(tick_event(32'd11, $urandom, 1'b0));
        send_event(tick_event(32'd27, $urandom, 1'b0));
        send_event(tick_event(32'd59, $urandom, 1'b0));
        wait_for_drain();
    endtask

    task automatic test_retry_limit_zero();
        set_config(3'd0, 4'd1);
        send_event(tick_event(32'd0, $urandom, 1'b0));
        send_event(tick_event(32'd5, $urandom, 1'b0));
        send_event(reply_event(dhcpc_pkg::MSG_OFFER, $urandom));
        send_event(tick_event(32'hFFFF_FFFF, $urandom, 1'b1));
        send_event(tick_event($urandom, $urandom, 1'b0));
        wait_for_drain();
    endtask

    task automatic test_long_backoff();
        set_config(3'd7, 4'd15);
        run_random_traffic(300);
        wait_for_drain();
    endtask

    task automatic test_short_backoff_no_gaps();
        set_config(3'd1, 4'd1);
        feed_gaps = 1'b0;
        drain_stalls = 1'b0;
        run_random_traffic(300);
        wait_for_drain();
        feed_gaps = 1'b1;
        drain_stalls = 1'b1;
    endtask

    task automatic test_random_settings();
        set_config(3'd3, 4'd8);
        run_random_traffic(300);
        set_config(3'($urandom_range(1, 7)), 4'($urandom_range(1, 15)));
        run_random_traffic(300);
        wait_for_drain();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_lease_sequence();
        test_retry_limit_zero();
        test_long_backoff();
        test_short_backoff_no_gaps();
        test_random_settings();
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
design/dhcpc_pkg.sv
design/dhcpc_in_stage.sv
design/dhcpc_core.sv
design/dhcp_client_state_machine.sv
bench/tb_dhcp_client_state_machine.sv
